/* rtl/core/kvq_pkg.sv */
// kvq_pkg: shared types and constants for the key/value query parser.
// Used by kvq_ctl, kvq_dp and key_value_query_parser; depends on nothing.
package kvq_pkg;

    // Default depth of the trailing-whitespace store
    localparam int unsigned MAX_PENDING_DEF = 16;

    // Result kinds carried on m_tuser
    typedef enum logic [2:0] {
        KIND_KEY_BYTE  = 3'd0,
        KIND_VAL_BYTE  = 3'd1,
        KIND_KEY_END   = 3'd2,
        KIND_VAL_END   = 3'd3,
        KIND_DONE      = 3'd4,
        KIND_NO_DELIM  = 3'd5,
        KIND_BAD_ESC   = 3'd6,
        KIND_OVERFLOW  = 3'd7
    } kind_t;

    // Configuration register indexes
    localparam logic [1:0] REG_PAIR_DELIM   = 2'd0;
    localparam logic [1:0] REG_KV_DELIM     = 2'd1;
    localparam logic [1:0] REG_OPTION_FLAGS = 2'd2;

    // Register reset values
    localparam logic [7:0] PAIR_DELIM_RST = 8'd38;
    localparam logic [7:0] KV_DELIM_RST   = 8'd61;
    localparam logic [2:0] OPTIONS_RST    = 3'd0;

    // Option bits
    localparam int unsigned OPT_LOWER  = 0;
    localparam int unsigned OPT_DECODE = 1;
    localparam int unsigned OPT_TRIM   = 2;

    // Characters
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CASE_OFS = 8'd32;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'd10;

    // Which part of an item's result sequence is being sent
    typedef enum logic [1:0] {
        SEL_FLUSH = 2'd0,
        SEL_MAIN  = 2'd1,
        SEL_TAIL0 = 2'd2,
        SEL_TAIL1 = 2'd3
    } sel_t;

    // Controller -> datapath
    typedef struct packed {
        logic load_plan;   // input transfer: update parse state, latch result plan
        logic emit;        // load one result into the output register
        sel_t sel;         // which result
        logic last;        // final result of the item
    } ctl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic nx_flush;    // plan of the offered input: pending whitespace to send
        logic nx_main;     // plan of the offered input: data byte or field end
        logic nx_tail;     // plan of the offered input: error or end-of-text results
        logic flush_last;  // current flush entry is the final one
        logic has_main;
        logic tail_any;
        logic tail_two;
        logic out_free;    // output register can take a result this cycle
    } dp_stat_t;

endpackage

/* rtl/core/key_value_query_parser.sv */
// key_value_query_parser: top level of the streaming key/value splitter.
// Depends on kvq_pkg, kvq_ctl and kvq_dp.
//
// Splits a byte stream (s_tdata, s_tlast ends the text) into key and value
// results on the master stream: m_tuser gives the kind (key byte, value byte,
// key end, value end, done, no delimiter, bad escape, overflow), m_tdata the
// character for byte kinds and zero otherwise, and m_tlast marks the final
// result caused by one input transfer. A key runs up to kv_delim, a value up
// to pair_delim. option_flags bit0 lowercases key letters, bit1 decodes %HH in
// values (either hex case), bit2 drops leading spaces/tabs of a field and
// parks trailing ones, releasing them only when a non-space byte of the same
// field follows; the last field is trimmed too. After an error result the
// block swallows bytes until the end of the text. An input that yields no
// result leaves the sequencer idle; otherwise the next input is taken on the
// cycle that the final result enters the output register. An input can yield
// up to MAX_PENDING + 3 results when parked whitespace is released ahead of
// a closing byte, value end and done, one result per cycle while m_tready
// allows, through the single output register. Configuration is to be written
// through cfg_we/cfg_index/cfg_data while the block is idle; the user must keep
// to this, as the block does not enforce it. Index 3 is ignored.
module key_value_query_parser #(
    parameter int unsigned MAX_PENDING = kvq_pkg::MAX_PENDING_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] in_byte
    input  logic       s_tlast,    // in_last
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] out_byte
    output logic [2:0] m_tuser,    // [2:0] out_kind
    output logic       m_tlast,    // out_run_last
    // config write port
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    kvq_pkg::ctl_cmd_t cmd;
    kvq_pkg::dp_stat_t stat;

    kvq_ctl u_ctl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kvq_dp #(
        .MAX_PENDING (MAX_PENDING)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .cmd       (cmd),
        .stat      (stat)
    );

    // a result is only loaded when the output register can take it
    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result loaded into a full output register");

    // a new input must not enter while the previous item still has results left
    a_no_early_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> !(cmd.emit && !cmd.last))
        else $error("input taken in the middle of a result sequence");

    // the final-result mark only goes with an actual transfer load
    a_last_with_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.last |-> cmd.emit)
        else $error("last mark without a result");

    // non-character kinds carry a zero byte
    a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != kvq_pkg::KIND_KEY_BYTE
            && m_tuser != kvq_pkg::KIND_VAL_BYTE) |-> (m_tdata == 8'd0))
        else $error("nonzero byte on a marker result");

endmodule

/* rtl/core/kvq_ctl.sv */
// kvq_ctl: sequencer that walks each item's results (flush, main, tail).
// Depends on kvq_pkg; drives kvq_dp through ctl_cmd_t.
module kvq_ctl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  kvq_pkg::dp_stat_t  stat,
    output kvq_pkg::ctl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FLUSH,
        S_MAIN,
        S_TAIL0,
        S_TAIL1
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t after_emit;
    state_t start_state;
    logic   emit;
    logic   done_now;
    logic   accept;

    always_comb
    begin
        unique case (state_reg)
            S_FLUSH:
            begin
                if (!stat.flush_last)
                    after_emit = S_FLUSH;
                else if (stat.has_main)
                    after_emit = S_MAIN;
                else if (stat.tail_any)
                    after_emit = S_TAIL0;
                else
                    after_emit = S_IDLE;
            end
            S_MAIN:  after_emit = stat.tail_any ? S_TAIL0 : S_IDLE;
            S_TAIL0: after_emit = stat.tail_two ? S_TAIL1 : S_IDLE;
            S_TAIL1: after_emit = S_IDLE;
            default: after_emit = S_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (stat.nx_flush)
            start_state = S_FLUSH;
        else if (stat.nx_main)
            start_state = S_MAIN;
        else if (stat.nx_tail)
            start_state = S_TAIL0;
        else
            start_state = S_IDLE;
    end

    assign emit     = (state_reg != S_IDLE) && stat.out_free;
    assign done_now = emit && (after_emit == S_IDLE);
    // next item may enter on the cycle the previous one's final result is loaded into the output register
    assign s_tready = (state_reg == S_IDLE) || done_now;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        priority if (accept)
            state_next = start_state;
        else if (emit)
            state_next = after_emit;
        else
            state_next = state_reg;
    end

    always_comb
    begin
        cmd.load_plan = accept;
        cmd.emit      = emit;
        cmd.last      = done_now;
        unique case (state_reg)
            S_FLUSH: cmd.sel = kvq_pkg::SEL_FLUSH;
            S_MAIN:  cmd.sel = kvq_pkg::SEL_MAIN;
            S_TAIL0: cmd.sel = kvq_pkg::SEL_TAIL0;
            S_TAIL1: cmd.sel = kvq_pkg::SEL_TAIL1;
            default: cmd.sel = kvq_pkg::SEL_MAIN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

/* rtl/core/kvq_dp.sv */
// kvq_dp: parse state, config registers, pending-whitespace store, result plan
// and output register. Depends on kvq_pkg; commanded by kvq_ctl.
module kvq_dp #(
    parameter int unsigned MAX_PENDING = kvq_pkg::MAX_PENDING_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // config
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    // input payload
    input  logic [7:0]         in_byte,
    input  logic               in_last,
    // output register
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         out_kind,
    output logic [7:0]         out_byte,
    output logic               out_last,
    // control
    input  kvq_pkg::ctl_cmd_t  cmd,
    output kvq_pkg::dp_stat_t  stat
);

    localparam int unsigned IDX_W = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_PENDING + 1);

    typedef enum logic [1:0] {
        PH_KEY,
        PH_VAL,
        PH_ESC_HI,
        PH_ESC_LO
    } phase_t;

    // returns {bad, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        begin
            d = 8'd0;
            if (c >= kvq_pkg::CH_0 && c <= kvq_pkg::CH_9)
            begin
                d = c - kvq_pkg::CH_0;
                hex_val = {1'b0, d[3:0]};
            end
            else if (c >= kvq_pkg::CH_LA && c <= kvq_pkg::CH_LF)
            begin
                d = c - kvq_pkg::CH_LA + kvq_pkg::HEX_ALPHA_OFS;
                hex_val = {1'b0, d[3:0]};
            end
            else if (c >= kvq_pkg::CH_UA && c <= kvq_pkg::CH_UF)
            begin
                d = c - kvq_pkg::CH_UA + kvq_pkg::HEX_ALPHA_OFS;
                hex_val = {1'b0, d[3:0]};
            end
            else
                hex_val = 5'h10;
        end
    endfunction

    // config
    logic [7:0] pair_delim_reg;
    logic [7:0] kv_delim_reg;
    logic [2:0] options_reg;

    // parse state
    phase_t     phase_reg,   phase_next;
    logic       started_reg, started_next;
    logic [3:0] hn_reg,      hn_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic       halt_reg,    halt_next;
    logic       pend_tab_reg [MAX_PENDING];

    // result plan of the item in flight
    logic [CNT_W-1:0] flush_n_reg,   flush_n_next;
    kvq_pkg::kind_t   flush_kind_reg, flush_kind_next;
    logic             main_reg,      main_next;
    kvq_pkg::kind_t   main_kind_reg, main_kind_next;
    logic [7:0]       main_byte_reg, main_byte_next;
    logic [1:0]       tail_n_reg,    tail_n_next;
    kvq_pkg::kind_t   tail_kind_reg, tail_kind_next;
    logic [IDX_W-1:0] flush_idx_reg;

    // output register
    logic             out_valid_reg;
    kvq_pkg::kind_t   out_kind_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;

    // step logic scratch
    logic             pc_do;
    kvq_pkg::kind_t   pc_kind;
    logic [7:0]       pc_ch;
    logic             pc_ws;
    logic             err;
    kvq_pkg::kind_t   err_kind;
    logic             wr_en;
    logic             wr_tab;
    logic [4:0]       hx;
    logic             esc_bad;

    kvq_pkg::kind_t   emit_kind;
    logic [7:0]       emit_byte;

    assign hx      = hex_val(in_byte);
    assign esc_bad = (in_byte == pair_delim_reg) || (in_byte == kv_delim_reg) || hx[4];

    always_comb
    begin
        phase_next      = phase_reg;
        started_next    = started_reg;
        hn_next         = hn_reg;
        cnt_next        = cnt_reg;
        halt_next       = halt_reg;
        flush_n_next    = '0;
        flush_kind_next = kvq_pkg::KIND_KEY_BYTE;
        main_next       = 1'b0;
        main_kind_next  = kvq_pkg::KIND_KEY_BYTE;
        main_byte_next  = 8'd0;
        tail_n_next     = 2'd0;
        tail_kind_next  = kvq_pkg::KIND_VAL_END;
        pc_do           = 1'b0;
        pc_kind         = kvq_pkg::KIND_KEY_BYTE;
        pc_ch           = in_byte;
        pc_ws           = 1'b0;
        err             = 1'b0;
        err_kind        = kvq_pkg::KIND_BAD_ESC;
        wr_en           = 1'b0;
        wr_tab          = 1'b0;

        if (!halt_reg)
        begin
            unique case (phase_reg)
                PH_KEY:
                begin
                    if (in_byte == kv_delim_reg)
                    begin
                        main_next      = 1'b1;
                        main_kind_next = kvq_pkg::KIND_KEY_END;
                        phase_next     = PH_VAL;
                        started_next   = 1'b0;
                        cnt_next       = '0;
                    end
                    else
                    begin
                        pc_do   = 1'b1;
                        pc_kind = kvq_pkg::KIND_KEY_BYTE;
                        if (options_reg[kvq_pkg::OPT_LOWER] && in_byte >= kvq_pkg::CH_UA
                            && in_byte <= kvq_pkg::CH_UZ)
                            pc_ch = in_byte + kvq_pkg::CASE_OFS;
                    end
                end
                PH_VAL:
                begin
                    if (in_byte == pair_delim_reg)
                    begin
                        main_next      = 1'b1;
                        main_kind_next = kvq_pkg::KIND_VAL_END;
                        phase_next     = PH_KEY;
                        started_next   = 1'b0;
                        cnt_next       = '0;
                    end
                    else if (options_reg[kvq_pkg::OPT_DECODE] && in_byte == kvq_pkg::CH_PCT)
                        phase_next = PH_ESC_HI;
                    else
                    begin
                        pc_do   = 1'b1;
                        pc_kind = kvq_pkg::KIND_VAL_BYTE;
                    end
                end
                PH_ESC_HI:
                begin
                    if (esc_bad)
                        err = 1'b1;
                    else
                    begin
                        hn_next    = hx[3:0];
                        phase_next = PH_ESC_LO;
                    end
                end
                default:
                begin
                    if (esc_bad)
                        err = 1'b1;
                    else
                    begin
                        phase_next = PH_VAL;
                        pc_do      = 1'b1;
                        pc_kind    = kvq_pkg::KIND_VAL_BYTE;
                        pc_ch      = {hn_reg, hx[3:0]};
                    end
                end
            endcase

            // one data byte of a field: with trimming on, leading whitespace is dropped
            // and later whitespace parked; any other byte first releases what is parked
            if (pc_do)
            begin
                pc_ws = (pc_ch == kvq_pkg::CH_SP) || (pc_ch == kvq_pkg::CH_TAB);
                if (options_reg[kvq_pkg::OPT_TRIM] && pc_ws)
                begin
                    if (started_reg)
                    begin
                        if (cnt_reg == CNT_W'(MAX_PENDING))
                        begin
                            err      = 1'b1;
                            err_kind = kvq_pkg::KIND_OVERFLOW;
                        end
                        else
                        begin
                            wr_en    = 1'b1;
                            wr_tab   = (pc_ch == kvq_pkg::CH_TAB);
                            cnt_next = cnt_reg + CNT_W'(1);
                        end
                    end
                end
                else
                begin
                    flush_n_next    = cnt_reg;
                    flush_kind_next = pc_kind;
                    cnt_next        = '0;
                    main_next       = 1'b1;
                    main_kind_next  = pc_kind;
                    main_byte_next  = pc_ch;
                    started_next    = 1'b1;
                end
            end

            if (!err && in_last)
            begin
                priority if (phase_next == PH_KEY)
                begin
                    err      = 1'b1;
                    err_kind = kvq_pkg::KIND_NO_DELIM;
                end
                else if (phase_next != PH_VAL)
                    err = 1'b1;
                else
                begin
                    tail_n_next    = 2'd2;
                    tail_kind_next = kvq_pkg::KIND_VAL_END;
                end
            end

            if (err)
            begin
                tail_n_next    = 2'd1;
                tail_kind_next = err_kind;
                halt_next      = !in_last;
            end
        end

        // end of text restores the parse state
        if (in_last)
        begin
            phase_next   = PH_KEY;
            hn_next      = 4'd0;
            started_next = 1'b0;
            cnt_next     = '0;
            halt_next    = 1'b0;
        end
    end

    always_comb
    begin
        unique case (cmd.sel)
            kvq_pkg::SEL_FLUSH:
            begin
                emit_kind = flush_kind_reg;
                emit_byte = pend_tab_reg[flush_idx_reg] ? kvq_pkg::CH_TAB : kvq_pkg::CH_SP;
            end
            kvq_pkg::SEL_MAIN:
            begin
                emit_kind = main_kind_reg;
                emit_byte = main_byte_reg;
            end
            kvq_pkg::SEL_TAIL0:
            begin
                emit_kind = tail_kind_reg;
                emit_byte = 8'd0;
            end
            default:
            begin
                emit_kind = kvq_pkg::KIND_DONE;
                emit_byte = 8'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_delim_reg <= kvq_pkg::PAIR_DELIM_RST;
            kv_delim_reg   <= kvq_pkg::KV_DELIM_RST;
            options_reg    <= kvq_pkg::OPTIONS_RST;
            phase_reg      <= PH_KEY;
            started_reg    <= 1'b0;
            hn_reg         <= 4'd0;
            cnt_reg        <= '0;
            halt_reg       <= 1'b0;
            flush_n_reg    <= '0;
            flush_kind_reg <= kvq_pkg::KIND_KEY_BYTE;
            main_reg       <= 1'b0;
            main_kind_reg  <= kvq_pkg::KIND_KEY_BYTE;
            tail_n_reg     <= 2'd0;
            tail_kind_reg  <= kvq_pkg::KIND_VAL_END;
            flush_idx_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    kvq_pkg::REG_PAIR_DELIM:   pair_delim_reg <= cfg_data;
                    kvq_pkg::REG_KV_DELIM:     kv_delim_reg   <= cfg_data;
                    kvq_pkg::REG_OPTION_FLAGS: options_reg    <= cfg_data[2:0];
                    default:                   ;
                endcase
            end

            if (cmd.load_plan)
            begin
                phase_reg      <= phase_next;
                started_reg    <= started_next;
                hn_reg         <= hn_next;
                cnt_reg        <= cnt_next;
                halt_reg       <= halt_next;
                flush_n_reg    <= flush_n_next;
                flush_kind_reg <= flush_kind_next;
                main_reg       <= main_next;
                main_kind_reg  <= main_kind_next;
                tail_n_reg     <= tail_n_next;
                tail_kind_reg  <= tail_kind_next;
                flush_idx_reg  <= '0;
            end
            else if (cmd.emit && cmd.sel == kvq_pkg::SEL_FLUSH)
                flush_idx_reg <= flush_idx_reg + IDX_W'(1);

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_plan)
            main_byte_reg <= main_byte_next;
        if (cmd.load_plan && wr_en)
            pend_tab_reg[cnt_reg[IDX_W-1:0]] <= wr_tab;
        if (cmd.emit)
        begin
            out_kind_reg <= emit_kind;
            out_byte_reg <= emit_byte;
            out_last_reg <= cmd.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        stat.nx_flush   = (flush_n_next != '0);
        stat.nx_main    = main_next;
        stat.nx_tail    = (tail_n_next != 2'd0);
        stat.flush_last = ((CNT_W'(flush_idx_reg) + CNT_W'(1)) == flush_n_reg);
        stat.has_main   = main_reg;
        stat.tail_any   = (tail_n_reg != 2'd0);
        stat.tail_two   = (tail_n_reg == 2'd2);
        stat.out_free   = !out_valid_reg || out_ready;
    end

endmodule
